@@ hdl/mp2a_pkg.sv @@
// shared types and constants of the 2x2 max pooling unit with argmax
`timescale 1ns / 1ps

package mp2a_pkg;

    localparam int VAL_W     = 32;
    localparam int POS_W     = 22;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_entry;

    typedef struct packed {
        logic                    valid;
        logic                    merge;
        logic                    done;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_pair_word;

endpackage

@@ hdl/max_pool_2x2_argmax_unit.sv @@
// 2x2 stride-2 max pooling with argmax, top level
// a window's closing word passes the merge stage register, then the output register
// throughput: one word per cycle unless stalled; per word at most one row store read or write
// words that only open a window or park a pair in the row store give no result
// reset: synchronous active low; settings return to 2x2, one channel, counters to zero
// row store content is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module max_pool_2x2_argmax_unit import mp2a_pkg::*; #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_pooled_value,
    output logic [POS_W-1:0]        o_argmax_position,
    output logic                    o_frame_done
);

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic       accept;
    logic       hold;
    logic       mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    t_entry     mem_wdata, mem_rdata;
    t_pair_word pair;

    assign o_stall = hold;
    assign accept  = i_valid && !hold;

    mp2a_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS),
        .AW          (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_sample   (i_sample),
        .o_mem_we   (mem_we),
        .o_mem_re   (mem_re),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata),
        .o_pair     (pair)
    );

    mp2a_row_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_addr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    mp2a_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pair           (pair),
        .i_rd_data        (mem_rdata),
        .i_stall          (i_stall),
        .o_hold           (hold),
        .o_valid          (o_valid),
        .o_pooled_value   (o_pooled_value),
        .o_argmax_position(o_argmax_position),
        .o_frame_done     (o_frame_done)
    );

endmodule

@@ hdl/mp2a_row_store.sv @@
// row store of pair maxima and their positions, registered read data
`timescale 1ns / 1ps

module mp2a_row_store import mp2a_pkg::*; #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mp2a_front.sv @@
// configuration, scan counters, pair compare and row store requests
`timescale 1ns / 1ps

module mp2a_front import mp2a_pkg::*; #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 64,
    parameter int AW           = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_accept,
    input  logic signed [VAL_W-1:0] i_sample,
    output logic                    o_mem_we,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_addr,
    output t_entry                  o_mem_wdata,
    output t_pair_word              o_pair
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int PW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int NW  = $clog2(MAX_CHANNELS + 1);

    logic [8:0]              r_frame_width;
    logic [8:0]              r_frame_height;
    logic [6:0]              r_channel_count;
    logic [CW-1:0]           r_col, n_col;
    logic [RW-1:0]           r_row, n_row;
    logic [PW-1:0]           r_plane, n_plane;
    logic [POS_W-1:0]        r_flat, n_flat;
    logic signed [VAL_W-1:0] r_held_value;
    logic [POS_W-1:0]        r_held_pos;

    logic [WW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;
    logic [NW-1:0]           c_eff;
    logic                    last_col, last_row, last_plane;
    logic                    have;
    logic                    cfg_hit;
    logic signed [VAL_W-1:0] pair_value;
    logic [POS_W-1:0]        pair_pos;

    // out-of-range settings: zero acts as one, too large acts as the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
        if (r_channel_count == '0) begin
            c_eff = NW'(1);
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            c_eff = NW'(MAX_CHANNELS);
        end else begin
            c_eff = NW'(r_channel_count);
        end
    end

    assign last_col   = ({1'b0, r_col} + 1'b1) >= (CW + 1)'(w_eff);
    assign last_row   = ({1'b0, r_row} + 1'b1) >= (RW + 1)'(h_eff);
    assign last_plane = ({1'b0, r_plane} + 1'b1) >= (PW + 1)'(c_eff);

    // only a write to a known register restarts the frame
    assign cfg_hit = i_cfg_we && ((i_cfg_index == CFG_FRAME_WIDTH) ||
                                  (i_cfg_index == CFG_FRAME_HEIGHT) ||
                                  (i_cfg_index == CFG_CHANNEL_COUNT));

    // pair maximum, left sample wins ties
    always_comb begin
        if (!r_col[0]) begin
            have       = last_col;
            pair_value = i_sample;
            pair_pos   = r_flat;
        end else if (r_held_value >= i_sample) begin
            have       = 1'b1;
            pair_value = r_held_value;
            pair_pos   = r_held_pos;
        end else begin
            have       = 1'b1;
            pair_value = i_sample;
            pair_pos   = r_flat;
        end
    end

    assign o_mem_addr           = AW'(r_col >> 1);
    assign o_mem_we             = i_accept && have && !r_row[0] && !last_row;
    assign o_mem_re             = i_accept && have && r_row[0];
    assign o_mem_wdata.value    = pair_value;
    assign o_mem_wdata.position = pair_pos;

    assign o_pair.valid    = i_accept && have && (r_row[0] || last_row);
    assign o_pair.merge    = r_row[0];
    assign o_pair.done     = last_col && last_row && last_plane;
    assign o_pair.value    = pair_value;
    assign o_pair.position = pair_pos;

    // scan position update
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        n_flat  = r_flat;
        if (cfg_hit) begin
            n_col   = '0;
            n_row   = '0;
            n_plane = '0;
            n_flat  = '0;
        end else if (i_accept) begin
            n_flat = r_flat + 1'b1;
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row = '0;
                    if (last_plane) begin
                        n_plane = '0;
                        n_flat  = '0;
                    end else begin
                        n_plane = r_plane + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 9'd2;
            r_frame_height  <= 9'd2;
            r_channel_count <= 7'd1;
            r_col           <= '0;
            r_row           <= '0;
            r_plane         <= '0;
            r_flat          <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
            r_flat  <= n_flat;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                    CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_col[0]) begin
            r_held_value <= i_sample;
            r_held_pos   <= r_flat;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW + 1)'(r_col) < (WW + 1)'(w_eff))
        else $error("column count beyond frame width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (HW + 1)'(r_row) < (HW + 1)'(h_eff))
        else $error("row count beyond frame height");

    a_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && (o_mem_re || o_pair.valid)))
        else $error("row store written by an item that also emits");

endmodule

@@ hdl/mp2a_merge.sv @@
// vertical merge with the stored pair and output register
`timescale 1ns / 1ps

module mp2a_merge import mp2a_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pair_word              i_pair,
    input  t_entry                  i_rd_data,
    input  logic                    i_stall,
    output logic                    o_hold,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_pooled_value,
    output logic [POS_W-1:0]        o_argmax_position,
    output logic                    o_frame_done
);

    t_pair_word              r_s1;
    logic                    r_o_valid;
    logic signed [VAL_W-1:0] r_o_value;
    logic [POS_W-1:0]        r_o_pos;
    logic                    r_o_done;
    logic                    adv;
    logic                    take_top;

    assign adv      = !r_o_valid || !i_stall;
    assign o_hold   = r_s1.valid && !adv;
    // upper pair wins ties
    assign take_top = r_s1.merge && (i_rd_data.value >= r_s1.value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_pair.valid) begin
                r_s1 <= i_pair;
            end else if (adv) begin
                r_s1.valid <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= r_s1.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1.valid) begin
            r_o_value <= take_top ? i_rd_data.value : r_s1.value;
            r_o_pos   <= take_top ? i_rd_data.position : r_s1.position;
            r_o_done  <= r_s1.done;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_pooled_value    = r_o_value;
    assign o_argmax_position = r_o_pos;
    assign o_frame_done      = r_o_done;

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |-> r_o_valid)
        else $error("upstream held while output register is free");

    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |=> r_s1.valid)
        else $error("held merge word lost");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |-> !i_pair.valid)
        else $error("new word entered while merge stage held");

endmodule

@@ verif/max_pool_2x2_argmax_checker.sv @@
// checker for the 2x2 max pooling unit: predicts each window result and compares it
`timescale 1ns / 1ps

module max_pool_2x2_argmax_checker import mp2a_pkg::*; #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [VAL_W-1:0] i_sample,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [VAL_W-1:0] i_pooled_value,
    input  logic [POS_W-1:0]        i_argmax_position,
    input  logic                    i_frame_done,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int PAIR_SLOTS = (MAX_WIDTH + 1) / 2;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        logic                    done;
    } t_window_result;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [6:0]       planes_reg;

    t_entry           row_pairs [PAIR_SLOTS];
    t_entry           held;
    int               col_cnt;
    int               row_cnt;
    int               plane_cnt;
    logic [POS_W-1:0] flat_pos;

    t_window_result   awaiting_windows [$];
    int               fails = 0;

    function automatic int clamp_setting(input int v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    task automatic restart_frame();
        held      = '0;
        col_cnt   = 0;
        row_cnt   = 0;
        plane_cnt = 0;
        flat_pos  = '0;
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    task automatic fold_sample(input logic signed [VAL_W-1:0] s);
        int             w;
        int             h;
        int             c;
        int             slot;
        logic           last_col;
        logic           last_row;
        logic           last_plane;
        logic           have;
        logic           ready;
        t_entry         cand;
        t_entry         upper;
        t_window_result res;
        w          = clamp_setting(int'(width_reg), MAX_WIDTH);
        h          = clamp_setting(int'(height_reg), MAX_HEIGHT);
        c          = clamp_setting(int'(planes_reg), MAX_CHANNELS);
        last_col   = (col_cnt + 1 >= w);
        last_row   = (row_cnt + 1 >= h);
        last_plane = (plane_cnt + 1 >= c);
        slot       = (col_cnt / 2) % PAIR_SLOTS;
        ready      = 1'b0;
        cand.value    = s;
        cand.position = flat_pos;
        if (col_cnt % 2 == 0) begin
            held = cand;
            have = last_col;
        end else begin
            if ($signed(held.value) >= $signed(s)) cand = held;
            have = 1'b1;
        end
        if (have) begin
            if (row_cnt % 2 == 0) begin
                if (last_row) ready = 1'b1;
                else row_pairs[slot] = cand;
            end else begin
                upper = row_pairs[slot];
                if ($signed(upper.value) >= $signed(cand.value)) cand = upper;
                ready = 1'b1;
            end
        end
        if (ready) begin
            res.value    = cand.value;
            res.position = cand.position;
            res.done     = last_col && last_row && last_plane;
            awaiting_windows.push_back(res);
        end
        flat_pos = flat_pos + 1'b1;
        if (last_col) begin
            col_cnt = 0;
            if (last_row) begin
                row_cnt = 0;
                if (last_plane) begin
                    plane_cnt = 0;
                    flat_pos  = '0;
                end else begin
                    plane_cnt++;
                end
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_window_result want;
        if (!i_rst_n) begin
            width_reg  = 9'd2;
            height_reg = 9'd2;
            planes_reg = 7'd1;
            restart_frame();
            awaiting_windows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_CHANNEL_COUNT: begin
                        planes_reg = i_cfg_data[6:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) fold_sample(i_sample);
            if (i_out_valid && !i_out_stall) begin
                if (awaiting_windows.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    want = awaiting_windows.pop_front();
                    if (i_pooled_value !== want.value)
                        flag_mismatch($sformatf("pooled value %h, want %h",
                                                i_pooled_value, want.value));
                    if (i_argmax_position !== want.position)
                        flag_mismatch($sformatf("argmax position %0d, want %0d",
                                                i_argmax_position, want.position));
                    if (i_frame_done !== want.done)
                        flag_mismatch($sformatf("frame done %b, want %b",
                                                i_frame_done, want.done));
                end
            end
        end
        o_pending    <= awaiting_windows.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/testbench.sv @@
// top of the max pooling testbench: clock, reset, stimulus, stall pattern and verdict
`timescale 1ns / 1ps

module testbench;
    import mp2a_pkg::*;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic signed [VAL_W-1:0] i_sample    = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [VAL_W-1:0] o_pooled_value;
    logic [POS_W-1:0]        o_argmax_position;
    logic                    o_frame_done;

    int                      fail_count;
    int                      pending;
    logic                    calm = 1'b0;
    logic signed [VAL_W-1:0] recent_sample = '0;

    max_pool_2x2_argmax_unit #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pooled_value    (o_pooled_value),
        .o_argmax_position (o_argmax_position),
        .o_frame_done      (o_frame_done)
    );

    max_pool_2x2_argmax_checker #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_sample          (i_sample),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_pooled_value    (o_pooled_value),
        .i_argmax_position (o_argmax_position),
        .i_frame_done      (o_frame_done),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall before each result word
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    task automatic send_word(input logic signed [VAL_W-1:0] word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= word;
        recent_sample  = word;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // waits out the pipeline before touching the registers
    task automatic set_frame(input int w, input int h, input int c);
        hold_off();
        repeat (4) @(negedge i_clk);
        cfg_write(CFG_FRAME_WIDTH, CFG_W'(w));
        cfg_write(CFG_FRAME_HEIGHT, CFG_W'(h));
        cfg_write(CFG_CHANNEL_COUNT, CFG_W'(c));
    endtask

    function automatic logic signed [VAL_W-1:0] draw_sample();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return VAL_W'($urandom_range(0, 4)) - 32'sd2;
            3:       return recent_sample;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one 2x2 window per frame
        send_word(32'sh8000_0000);
        send_word(32'sh7FFF_FFFF);
        send_word(32'sh7FFF_FFFF);
        send_word(32'sh1234_5678);
        repeat (4) send_word(32'sd5);
        send_word(-32'sd1);
        send_word(-32'sd2);
        send_word(-32'sd3);
        send_word(32'sd0);

        // odd edges
        set_frame(3, 3, 1);
        send_word(32'sd1);
        send_word(32'sd9);
        send_word(-32'sd4);
        send_word(32'sd9);
        send_word(32'sd2);
        send_word(32'sd7);
        send_word(32'sh8000_0000);
        send_word(-32'sd7);
        send_word(32'sh7FFF_FFFF);

        set_frame(1, 1, 2);
        send_word(32'shAAAA_AAAA);
        send_word(32'sh5555_5555);

        for (int k = 0; k < 10; k++) begin
            int w;
            int h;
            int c;
            int count;
            case (k)
                0: begin
                    w = 0; h = 0; c = 0; count = 6;
                end
                1: begin
                    w = 9'h1FF; h = 1; c = 1; count = 258;
                end
                2: begin
                    w = 1; h = 9'h1FF; c = 1; count = 16;
                end
                3: begin
                    w = 1; h = 1; c = 9'h1FF; count = 66;
                end
                4: begin
                    w = 9'h100; h = 2; c = 2; count = 16;
                end
                5: begin
                    w = 2; h = 9'h100; c = 64; count = 12;
                end
                default: begin
                    w     = $urandom_range(1, 7);
                    h     = $urandom_range(1, 7);
                    c     = $urandom_range(1, 3);
                    count = $urandom_range(6, 16);
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            set_frame(w, h, c);
            if (k == 6) cfg_write(CFG_SPARE, CFG_W'($urandom));
            for (int j = 0; j < count; j++) begin
                if (j == count / 2 || $urandom_range(0, 39) == 0) hold_off();
                send_word(draw_sample());
            end
        end

        hold_off();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/mp2a_pkg.sv
hdl/mp2a_row_store.sv
hdl/mp2a_front.sv
hdl/mp2a_merge.sv
hdl/max_pool_2x2_argmax_unit.sv
verif/max_pool_2x2_argmax_checker.sv
verif/testbench.sv
